### rtl/otd_pkg.sv
// ---------------------------------------------------------------------------
// otd_pkg: shared types and constants of the OPC UA TCP deframer
// Header layout codes, character constants and the per-word result record.
// ---------------------------------------------------------------------------
package otd_pkg;

  // Header is always eight bytes: three type characters, one chunk flag and
  // a little-endian 32-bit total size.
  localparam int unsigned HDR_LEN = 8;

  // Three-character message types, first character in the upper byte.
  localparam logic [23:0] TY_HEL = 24'h48454C;
  localparam logic [23:0] TY_ACK = 24'h41434B;
  localparam logic [23:0] TY_ERR = 24'h455252;
  localparam logic [23:0] TY_MSG = 24'h4D5347;
  localparam logic [23:0] TY_OPN = 24'h4F504E;
  localparam logic [23:0] TY_CLO = 24'h434C4F;

  // Chunk flag characters.
  localparam logic [7:0] CHR_C = 8'h43;
  localparam logic [7:0] CHR_F = 8'h46;
  localparam logic [7:0] CHR_A = 8'h41;

  // Message type codes.
  localparam logic [2:0] MT_UNKNOWN = 3'd0;
  localparam logic [2:0] MT_HELLO   = 3'd1;
  localparam logic [2:0] MT_ACK     = 3'd2;
  localparam logic [2:0] MT_ERROR   = 3'd3;
  localparam logic [2:0] MT_SECURE  = 3'd4;

  // Secure message variants.
  localparam logic [1:0] SK_NONE  = 2'd0;
  localparam logic [1:0] SK_MSG   = 2'd1;
  localparam logic [1:0] SK_OPEN  = 2'd2;
  localparam logic [1:0] SK_CLOSE = 2'd3;

  // Chunk kinds.
  localparam logic [1:0] CK_UNKNOWN      = 2'd0;
  localparam logic [1:0] CK_INTERMEDIATE = 2'd1;
  localparam logic [1:0] CK_FINAL        = 2'd2;
  localparam logic [1:0] CK_ABORT        = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_TYPE  = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd2;
  localparam logic [1:0] ERR_TOO_SMALL = 2'd3;

  // Everything the parser reports for one byte.
  typedef struct packed {
    logic [7:0]  byte_out;
    logic        in_header;
    logic [2:0]  message_type;
    logic [1:0]  secure_kind;
    logic [1:0]  chunk_kind;
    logic [31:0] total_size;
    logic        message_end;
    logic [1:0]  error_code;
  } otd_result_t;

endpackage

### rtl/otd_parser.sv
// ---------------------------------------------------------------------------
// otd_parser: header decode and message state
// Holds the per-message state and works out the result for one byte.
// ---------------------------------------------------------------------------
module otd_parser #(
  parameter int SIZE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic [31:0]          max_message_size,
  output otd_pkg::otd_result_t result
);
  import otd_pkg::*;

  logic [SIZE_BITS-1:0] byte_count, byte_count_next, count_plus;
  logic [31:0]          declared_size, declared_size_next, size_word;
  logic [15:0]          type_hi, type_hi_next;
  logic [2:0]           kind, kind_next;
  logic [1:0]           variant, variant_next;
  logic [1:0]           chunk, chunk_next;
  logic [1:0]           err, err_next;
  logic [23:0]          type_word;
  logic                 hdr, msg_end;
  logic [31:0]          tsize;
  logic                 size_over;

  always_comb begin
    byte_count_next    = byte_count;
    declared_size_next = declared_size;
    type_hi_next       = type_hi;
    kind_next          = kind;
    variant_next       = variant;
    chunk_next         = chunk;
    err_next           = err;
    hdr                = 1'b0;
    msg_end            = 1'b0;
    tsize              = 32'd0;
    count_plus         = byte_count + SIZE_BITS'(1);
    type_word          = {type_hi, data_byte};
    size_word          = {data_byte, declared_size[23:0]};
    size_over          = ((size_word >> SIZE_BITS) != 32'd0) || (size_word > max_message_size);

    if (err == ERR_NONE) begin
      if (byte_count < SIZE_BITS'(HDR_LEN)) begin
        hdr = 1'b1;
        unique case (byte_count[2:0])
          3'd0: type_hi_next = {8'h00, data_byte};
          3'd1: type_hi_next = {type_hi[7:0], data_byte};
          3'd2: begin
            unique case (type_word)
              TY_HEL: kind_next = MT_HELLO;
              TY_ACK: kind_next = MT_ACK;
              TY_ERR: kind_next = MT_ERROR;
              TY_MSG: begin
                kind_next    = MT_SECURE;
                variant_next = SK_MSG;
              end
              TY_OPN: begin
                kind_next    = MT_SECURE;
                variant_next = SK_OPEN;
              end
              TY_CLO: begin
                kind_next    = MT_SECURE;
                variant_next = SK_CLOSE;
              end
              default: err_next = ERR_BAD_TYPE;
            endcase
          end
          3'd3: begin
            unique case (data_byte)
              CHR_C:   chunk_next = CK_INTERMEDIATE;
              CHR_F:   chunk_next = CK_FINAL;
              CHR_A:   chunk_next = CK_ABORT;
              default: chunk_next = CK_UNKNOWN;
            endcase
            // Only secure MSG may be split into chunks; all others must be final.
            if (chunk_next == CK_UNKNOWN) begin
              err_next = ERR_BAD_TYPE;
            end else if (!(kind == MT_SECURE && variant == SK_MSG) &&
                         chunk_next != CK_FINAL) begin
              err_next = ERR_BAD_TYPE;
            end
          end
          default: begin
            declared_size_next[{byte_count[1:0], 3'b000} +: 8] = data_byte;
            if (byte_count[2:0] == 3'd7) begin
              tsize = size_word;
              if (size_over) begin
                err_next = ERR_TOO_LARGE;
              end else if (size_word < 32'(HDR_LEN)) begin
                err_next = ERR_TOO_SMALL;
              end
            end
          end
        endcase
        if (err_next != ERR_NONE) begin
          hdr = 1'b0;
        end
      end else begin
        tsize = declared_size;
      end
      if (err_next == ERR_NONE) begin
        byte_count_next = count_plus;
        msg_end = (count_plus >= SIZE_BITS'(HDR_LEN)) &&
                  (32'(count_plus) == declared_size_next);
      end
    end else begin
      // Frozen after an error; the size seen so far (zero if none) is repeated.
      tsize = declared_size;
    end

    result.byte_out     = data_byte;
    result.in_header    = hdr;
    result.message_type = kind_next;
    result.secure_kind  = variant_next;
    result.chunk_kind   = chunk_next;
    result.total_size   = tsize;
    result.message_end  = msg_end;
    result.error_code   = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      declared_size <= '0;
      type_hi       <= '0;
      kind          <= MT_UNKNOWN;
      variant       <= SK_NONE;
      chunk         <= CK_UNKNOWN;
      err           <= ERR_NONE;
    end else if (step) begin
      err <= err_next;
      if (msg_end) begin
        byte_count    <= '0;
        declared_size <= '0;
        type_hi       <= '0;
        kind          <= MT_UNKNOWN;
        variant       <= SK_NONE;
        chunk         <= CK_UNKNOWN;
      end else begin
        byte_count    <= byte_count_next;
        declared_size <= declared_size_next;
        type_hi       <= type_hi_next;
        kind          <= kind_next;
        variant       <= variant_next;
        chunk         <= chunk_next;
      end
    end
  end

endmodule

### rtl/opc_ua_tcp_deframer_top.sv
// ---------------------------------------------------------------------------
// opc_ua_tcp_deframer_top: OPC UA TCP message deframer
// Parses the 8-byte message header in a received byte stream, tags every
// byte with the decoded header fields and marks the last byte of a message.
// ---------------------------------------------------------------------------
//
//   channel   dir  width  content
//   s_axis    in   8      one received stream byte per word
//   m_axis    out  40+10  byte, size in tdata; header fields, error in tuser
//   cfg       in   32     max_message_size, write only
//
// A word is parsed while it sits in the input register and moves into the
// output register when that one is empty or being drained, and is offered
// on m_axis from there. One word can be accepted every cycle. The input
// side stalls only while both registers are full and the sink is not taking
// the output word. Reset (rst, synchronous) clears the header state, the
// sticky error and the maximum size (back to 65536). A header error freezes
// parsing until reset; bytes still pass through with the frozen fields.
// ---------------------------------------------------------------------------
module opc_ua_tcp_deframer_top #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream. tdata: data_byte[7:0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Output stream. tdata: byte_out[7:0], total_size[39:8].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  // tuser: in_header[0], message_type[3:1], secure_kind[5:4],
  // chunk_kind[7:6], error_code[9:8].
  output logic [9:0]  m_axis_tuser,
  // High on the last byte of a message or chunk.
  output logic        m_axis_tlast,
  // Configuration: largest accepted total message size.
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import otd_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_valid;
  otd_result_t out_word;
  otd_result_t parsed;
  logic        advance;
  logic [31:0] max_message_size;

  // A word moves from the input register into the output register whenever
  // the output register is empty or is being drained this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_size <= 32'd65536;
    end else if (cfg_we) begin
      max_message_size <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  otd_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .data_byte        (in_byte),
    .max_message_size (max_message_size),
    .result           (parsed)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= parsed;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_word.total_size, out_word.byte_out};
  assign m_axis_tuser  = {out_word.error_code, out_word.chunk_kind, out_word.secure_kind,
                          out_word.message_type, out_word.in_header};
  assign m_axis_tlast  = out_word.message_end;

`ifndef NO_ASSERTIONS
  // A message never ends on a byte that carries an error.
  a_end_without_error: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[9:8] == ERR_NONE))
    else $error("message end marked together with an error");

  // A message that ends inside the header must be exactly header long.
  a_header_only_size: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast && m_axis_tuser[0]) |-> (m_axis_tdata[39:8] == 32'd8))
    else $error("header byte ends a message whose size is not eight");

  // Header bytes are only reported while no error is pending.
  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[9:8] == ERR_NONE))
    else $error("header byte reported with an error code");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the OPC UA TCP deframer
// Streams well-formed messages with random bodies through the block under
// several size limits, then ends with one randomly chosen header error and
// trailing noise. Every output word is checked against a local parser model.
// ---------------------------------------------------------------------------
module tb;
  import otd_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side

  // All six legal message types and the three legal chunk flags.
  localparam logic [23:0] KNOWN_TYPES [6] = '{TY_HEL, TY_ACK, TY_ERR, TY_MSG, TY_OPN, TY_CLO};
  localparam logic [7:0]  CHUNK_FLAGS [3] = '{CHR_C, CHR_F, CHR_A};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [9:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;

  // The clock toggles every half period; the full period is 12 ns.
  always #6 clk = ~clk;

  opc_ua_tcp_deframer_top #(
    .SIZE_BITS(32)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // -------------------------------------------------------------------------
  // Parser model. These variables mirror the block's header state; they start
  // at their reset values, which is valid since reset happens only once.
  // -------------------------------------------------------------------------
  logic [31:0] size_cap   = 32'd65536;
  logic [31:0] hdr_pos    = '0;   // bytes seen of the current message
  logic [31:0] decl_size  = '0;   // little-endian size as assembled so far
  logic [23:0] type_acc   = '0;   // type characters, first one ends up on top
  logic [2:0]  msg_kind   = MT_UNKNOWN;
  logic [1:0]  sec_var    = SK_NONE;
  logic [1:0]  chunk_fl   = CK_UNKNOWN;
  logic [1:0]  err_sticky = ERR_NONE;

  // Work out the output word for one stream byte and advance the model.
  function automatic otd_result_t parse_byte(input logic [7:0] b);
    otd_result_t r;
    logic [31:0] p;
    r = '0;
    r.byte_out = b;
    if (err_sticky == ERR_NONE) begin
      p = hdr_pos;
      if (p < HDR_LEN) begin
        r.in_header = 1'b1;
        if (p < 3) begin
          type_acc = {type_acc[15:0], b};
          // The type is decoded once its third character has arrived.
          if (p == 2) begin
            unique case (type_acc)
              TY_HEL: msg_kind = MT_HELLO;
              TY_ACK: msg_kind = MT_ACK;
              TY_ERR: msg_kind = MT_ERROR;
              TY_MSG: begin msg_kind = MT_SECURE; sec_var = SK_MSG; end
              TY_OPN: begin msg_kind = MT_SECURE; sec_var = SK_OPEN; end
              TY_CLO: begin msg_kind = MT_SECURE; sec_var = SK_CLOSE; end
              default: err_sticky = ERR_BAD_TYPE;
            endcase
          end
        end else if (p == 3) begin
          if (b == CHR_C) chunk_fl = CK_INTERMEDIATE;
          else if (b == CHR_F) chunk_fl = CK_FINAL;
          else if (b == CHR_A) chunk_fl = CK_ABORT;
          else begin
            chunk_fl = CK_UNKNOWN;
            err_sticky = ERR_BAD_TYPE;
          end
          // Only secure MSG traffic may be split into chunks or aborted.
          if (chunk_fl != CK_UNKNOWN && chunk_fl != CK_FINAL &&
              !(msg_kind == MT_SECURE && sec_var == SK_MSG))
            err_sticky = ERR_BAD_TYPE;
        end else begin
          decl_size = decl_size | (32'(b) << (8 * (p - 4)));
          if (p == 7) begin
            r.total_size = decl_size;
            // With 32 size bits every value fits, so only the limit matters.
            if (decl_size > size_cap) err_sticky = ERR_TOO_LARGE;
            else if (decl_size < HDR_LEN) err_sticky = ERR_TOO_SMALL;
          end
        end
        if (err_sticky != ERR_NONE) r.in_header = 1'b0;
      end else begin
        r.total_size = decl_size;
      end
      if (err_sticky == ERR_NONE) begin
        hdr_pos = p + 1;
        if (hdr_pos >= HDR_LEN && hdr_pos == decl_size) r.message_end = 1'b1;
      end
    end else if (hdr_pos >= HDR_LEN - 1 && decl_size != 0) begin
      // Frozen after an error: the size shows only if the header got that far.
      r.total_size = decl_size;
    end
    r.message_type = msg_kind;
    r.secure_kind  = sec_var;
    r.chunk_kind   = chunk_fl;
    r.error_code   = err_sticky;
    if (r.message_end) begin
      hdr_pos   = '0;
      decl_size = '0;
      type_acc  = '0;
      msg_kind  = MT_UNKNOWN;
      sec_var   = SK_NONE;
      chunk_fl  = CK_UNKNOWN;
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Shared bench state.
  // -------------------------------------------------------------------------
  logic [7:0]  rx_bytes[$];          // stream bytes still to be offered
  otd_result_t expected_words[$];    // predicted output words, oldest first
  int          bad_words = 0;        // mismatches plus unexpected words
  int          words_out = 0;        // output words taken so far
  bit          no_gaps = 1'b0;       // when set, neither side draws a random gap
  int          src_wait = 0;
  int          sink_wait = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;

  // -------------------------------------------------------------------------
  // Driver. When the current word is accepted it is run through the model,
  // then the next byte is offered after a random gap unless no_gaps is set.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_words.push_back(parse_byte(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait > 0) begin
          src_wait <= src_wait - 1;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes.size() > 0) begin
          s_axis_tdata <= rx_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          src_wait <= no_gaps ? 0 : $urandom_range(0, 4);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Long sink stall. Every 200 output words the sink holds off while the
  // driver keeps offering, so the pipeline fills and the block has to drop
  // s_axis_tready.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (m_axis_tvalid && m_axis_tready && words_out % 200 == 150) begin
      hold_left <= 60;
    end
  end

  // -------------------------------------------------------------------------
  // Monitor. Each output word is unpacked from tdata, tuser and tlast and
  // compared with the oldest prediction. After each word the sink draws a
  // random gap before it is ready again, unless no_gaps is set.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    otd_result_t got;
    otd_result_t want;
    int w;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else begin
      w = (sink_wait > 0) ? sink_wait - 1 : 0;
      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_out     = m_axis_tdata[7:0];
        got.total_size   = m_axis_tdata[39:8];
        got.in_header    = m_axis_tuser[0];
        got.message_type = m_axis_tuser[3:1];
        got.secure_kind  = m_axis_tuser[5:4];
        got.chunk_kind   = m_axis_tuser[7:6];
        got.error_code   = m_axis_tuser[9:8];
        got.message_end  = m_axis_tlast;
        if (expected_words.size() == 0) begin
          bad_words <= bad_words + 1;
          if (bad_words < 10)
            $display("word %0d arrived with no prediction pending: byte %h", words_out,
                     got.byte_out);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            bad_words <= bad_words + 1;
            if (bad_words < 10) begin
              $display("word %0d mismatch", words_out);
              $display(
                "  expected byte %h hdr %0d type %0d sec %0d chunk %0d size %0d end %0d err %0d",
                want.byte_out, want.in_header, want.message_type, want.secure_kind,
                want.chunk_kind, want.total_size, want.message_end, want.error_code);
              $display(
                "  got      byte %h hdr %0d type %0d sec %0d chunk %0d size %0d end %0d err %0d",
                got.byte_out, got.in_header, got.message_type, got.secure_kind,
                got.chunk_kind, got.total_size, got.message_end, got.error_code);
            end
          end
        end
        words_out <= words_out + 1;
        w = no_gaps ? 0 : $urandom_range(0, 4);
      end
      sink_wait <= w;
      m_axis_tready <= (w == 0) && (hold_left == 0);
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: a run in which no word moves for too long has hung.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers.
  // -------------------------------------------------------------------------
  task automatic queue_header(input logic [23:0] ty, input logic [7:0] fl,
                              input logic [31:0] sz);
    rx_bytes.push_back(ty[23:16]);
    rx_bytes.push_back(ty[15:8]);
    rx_bytes.push_back(ty[7:0]);
    rx_bytes.push_back(fl);
    rx_bytes.push_back(sz[7:0]);
    rx_bytes.push_back(sz[15:8]);
    rx_bytes.push_back(sz[23:16]);
    rx_bytes.push_back(sz[31:24]);
  endtask

  task automatic queue_noise(input int n);
    repeat (n) rx_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Well-formed messages with random bodies until about n bytes are queued.
  // Most are short; about one in twenty carries a body of up to 300 bytes.
  task automatic queue_traffic(input int n);
    int queued;
    int k;
    logic [23:0] ty;
    logic [7:0] fl;
    logic [31:0] sz;
    queued = 0;
    while (queued < n) begin
      k = $urandom_range(0, 5);
      ty = KNOWN_TYPES[k];
      fl = (ty == TY_MSG) ? CHUNK_FLAGS[$urandom_range(0, 2)] : CHR_F;
      if ($urandom_range(0, 19) == 0) sz = 8 + $urandom_range(0, 300);
      else sz = 8 + $urandom_range(0, 24);
      if (sz > size_cap) sz = size_cap;
      queue_header(ty, fl, sz);
      queue_noise(int'(sz) - 8);
      queued += int'(sz);
    end
  endtask

  // Block here until every queued byte has been accepted and answered.
  task automatic wait_drained();
    while (rx_bytes.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
      @(negedge clk);
  endtask

  // Registers are only written here, with the block drained.
  task automatic write_size_cap(input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    size_cap = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Test sequence. The sticky error can only be cleared by reset, and reset
  // happens once, so all well-formed traffic comes first and a single error,
  // chosen at random for this run, closes the run.
  // -------------------------------------------------------------------------
  initial begin : sequencer
    int kind;
    int i;
    bit known;
    logic [23:0] ty;
    logic [7:0] fl;
    logic [31:0] sz;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, at the reset limit: a header-only hello (size exactly
    // the header), a secure intermediate chunk with a zero body byte, and a
    // header-only acknowledge.
    queue_header(TY_HEL, CHR_F, 32'd8);
    queue_header(TY_MSG, CHR_C, 32'd9);
    rx_bytes.push_back(8'h00);
    queue_header(TY_ACK, CHR_F, 32'd8);
    wait_drained();

    // A limit of 9: only 8 and 9 byte messages fit.
    write_size_cap(32'd9);
    queue_traffic(80);
    wait_drained();

    // Largest limit, with no random gaps on either side.
    write_size_cap(32'hFFFF_FFFF);
    no_gaps = 1'b1;
    queue_traffic(220);
    wait_drained();
    no_gaps = 1'b0;

    // A random moderate limit, with random idling.
    write_size_cap(32'(9 + $urandom_range(0, 191)));
    queue_traffic(220);
    wait_drained();

    // Closing error, one kind per run, then noise that must pass through
    // with the frozen header fields.
    kind = $urandom_range(0, 4);
    ty = KNOWN_TYPES[$urandom_range(0, 5)];
    unique case (kind)
      0: begin
        // Unknown type: one flipped bit in a legal type.
        known = 1'b1;
        while (known) begin
          ty = KNOWN_TYPES[$urandom_range(0, 5)] ^ (24'd1 << $urandom_range(0, 23));
          known = 1'b0;
          for (i = 0; i < 6; i++) if (ty == KNOWN_TYPES[i]) known = 1'b1;
        end
        queue_header(ty, CHR_F, 32'd8);
      end
      1: begin
        // A flag character that is none of C, F, A.
        fl = CHR_C;
        while (fl == CHR_C || fl == CHR_F || fl == CHR_A) fl = 8'($urandom_range(0, 255));
        queue_header(ty, fl, 32'd8);
      end
      2: begin
        // A chunk or abort flag on a type that must be final.
        ty = KNOWN_TYPES[$urandom_range(0, 4) >= 3 ? $urandom_range(4, 5) :
                         $urandom_range(0, 2)];
        queue_header(ty, $urandom_range(0, 1) ? CHR_C : CHR_A, 32'd8);
      end
      3: begin
        // Size above the limit, just over it or far over it.
        if ($urandom_range(0, 1)) sz = size_cap + 1;
        else sz = $urandom() | 32'h8000_0000;
        queue_header(ty, (ty == TY_MSG) ? CHR_C : CHR_F, sz);
      end
      default: begin
        // Size smaller than the header itself.
        queue_header(ty, CHR_F, 32'($urandom_range(0, 7)));
      end
    endcase
    queue_noise(40);
    wait_drained();

    repeat (10) @(posedge clk);
    if (bad_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/otd_pkg.sv
rtl/otd_parser.sv
rtl/opc_ua_tcp_deframer_top.sv
bench/tb.sv
